// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the ramp engine modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// check an implication on every clock edge outside reset
`define ASSERT_IMP(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
// check an implication in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`else
`define ASSERT_IMP(label, clk, rst_n, pre, post)
`define ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// ----- hw/rtl/mclre_pkg.sv -----
// Types and constants of the linear ramp engine.
package mclre_pkg;
	localparam int LEVEL_W = 32;
	localparam int IDX_W   = 4;
	localparam int CMD_W   = 2;
	localparam int TKS_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [CMD_W-1:0] CMD_SET  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RAMP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_CONTROLS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MASK     = 1'd1;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [IDX_W-1:0]   control_index;
		logic signed [LEVEL_W-1:0] level;
		logic [TKS_W-1:0]   ramp_ticks;
	} cmd_t;

	typedef struct packed {
		logic [IDX_W-1:0]   out_index;
		logic signed [LEVEL_W-1:0] out_level;
		logic               status;
		logic               last;
	} res_t;

	// classified command passed from front to back
	typedef enum logic [1:0] {
		OP_SET    = 2'd0,
		OP_RAMP   = 2'd1,
		OP_TICK   = 2'd2,
		OP_REJECT = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [IDX_W-1:0]   idx;
		logic [LEVEL_W-1:0] level;
		logic [TKS_W-1:0]   ticks;
	} job_t;
endpackage

// ----- hw/rtl/mclre_if.sv -----
// Valid/ready channel interface.
interface mclre_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/mclre_front.sv -----
// Front end: accepts commands, classifies them and queues jobs.
module mclre_front #(
	parameter int NUM_CONTROLS = 16,
	parameter int TICK_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	mclre_if.sink in_ch,
	input  logic [4:0] controls_in_use,
	input  logic [15:0] continuous_mask,
	output mclre_pkg::job_t job,
	output logic job_valid,
	input  logic job_ready
);
	import mclre_pkg::*;
	localparam int QD = 2;

	job_t q_mem_q [QD];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;
	job_t nj;
	logic [5:0] lim;
	logic push, pop;

	// clamp the control count to the instantiated controls
	always_comb begin
		lim = ({1'b0, controls_in_use} < 6'(NUM_CONTROLS)) ? {1'b0, controls_in_use}
			: 6'(NUM_CONTROLS);
	end

	// classify the incoming beat; a direct write that keeps ramps carries zero ticks
	always_comb begin
		nj.idx = in_ch.data.control_index;
		nj.level = in_ch.data.level;
		nj.ticks = in_ch.data.ramp_ticks & TKS_W'((64'd1 << TICK_WIDTH) - 64'd1);
		if (nj.ticks == '0) nj.ticks = TKS_W'(1);
		nj.op = OP_TICK;
		unique case (in_ch.data.command)
			CMD_SET, CMD_RAMP: begin
				if ({2'b0, in_ch.data.control_index} >= lim) nj.op = OP_REJECT;
				else if (in_ch.data.command == CMD_RAMP
					&& continuous_mask[in_ch.data.control_index]) nj.op = OP_RAMP;
				else if (in_ch.data.command == CMD_RAMP) nj.op = OP_SET;
				else nj.op = OP_SET;
			end
			default: nj.op = OP_TICK;
		endcase
		if (nj.op == OP_SET && in_ch.data.command != CMD_SET) nj.ticks = '0;
	end

	assign in_ch.ready = (cnt_q != 2'(QD));
	assign push = in_ch.valid && in_ch.ready && (in_ch.data.command != 2'd3);
	assign job_valid = (cnt_q != 0);
	assign pop = job_valid && job_ready;
	always_comb begin
		job = q_mem_q[rp_q];
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wp_q] <= nj;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMP(a_no_overflow, clk, arst_n, cnt_q == 2'(QD), !push)
	`ASSERT_NEXT(a_cnt_push, clk, arst_n, push && !pop, cnt_q == $past(cnt_q) + 2'd1)
	`ASSERT_IMP(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 2'(QD))
endmodule

// ----- hw/rtl/mclre_div.sv -----
// Serial restoring divider for the ramp step.
module mclre_div #(
	parameter int NW = 49,
	parameter int DW = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic busy,
	output logic [NW-1:0] quo
);
	localparam int CW = $clog2(NW + 1);
	logic [NW-1:0] q_q;
	logic [DW:0] r_q;
	logic [DW-1:0] d_q;
	logic [CW-1:0] n_q;
	logic [DW:0] trial;
	logic [DW:0] sh;

	assign sh = {r_q[DW-1:0], q_q[NW-1]};
	assign trial = sh - {1'b0, d_q};
	assign quo = q_q;

	// shift one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy) begin
			if (!trial[DW]) begin
				r_q <= trial;
				q_q <= {q_q[NW-2:0], 1'b1};
			end else begin
				r_q <= sh;
				q_q <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0;
		end else if (start) begin
			n_q <= CW'(NW);
		end else if (busy) begin
			n_q <= n_q - CW'(1);
		end
	end
	assign busy = (n_q != '0);
endmodule

// ----- hw/rtl/mclre_back.sv -----
// Back end: holds control state, runs ramps and produces result beats.
module mclre_back #(
	parameter int NUM_CONTROLS = 16,
	parameter int TICK_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  mclre_pkg::job_t job,
	input  logic job_valid,
	output logic job_ready,
	input  logic [4:0] controls_in_use,
	mclre_if.source out_ch
);
	import mclre_pkg::*;
	localparam int CI = (NUM_CONTROLS > 1) ? $clog2(NUM_CONTROLS) : 1;
	localparam int CW = CI + 1;
	localparam int TW = TICK_WIDTH;
	localparam int NW = 33 + TW;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_SCAN = 5'b00010,
		ST_DIV  = 5'b00100,
		ST_WAIT = 5'b01000,
		ST_EMIT = 5'b10000
	} st_t;

	st_t st_q;
	logic [31:0] cur_q [NUM_CONTROLS];
	logic [31:0] start_q [NUM_CONTROLS];
	logic [31:0] tgt_q [NUM_CONTROLS];
	logic [TW-1:0] left_q [NUM_CONTROLS];
	logic [TW-1:0] tot_q [NUM_CONTROLS];
	logic [CW-1:0] i_q;
	logic [CI-1:0] ii;
	logic [CW-1:0] pend_q;
	logic pend_v_q;
	logic [31:0] pend_lvl_q;
	logic out_v_q;
	logic out_set;
	res_t out_q;
	logic neg_q;
	logic [31:0] tgtl_q;
	logic [5:0] lim;

	// divider
	logic dstart, dbusy;
	logic [NW-1:0] dnum, dquo;
	logic [TW-1:0] dden;
	logic signed [32:0] diff;
	logic [32:0] mag;
	logic [TW-1:0] rem;
	logic div_go;
	logic [TW-1:0] dden_q;
	logic mul_q;

	assign ii = i_q[CI-1:0];
	assign lim = ({1'b0, controls_in_use} < 6'(NUM_CONTROLS)) ? {1'b0, controls_in_use}
		: 6'(NUM_CONTROLS);
	assign diff = 33'(signed'(start_q[ii])) - 33'(signed'(tgt_q[ii]));
	assign mag = diff[32] ? 33'(-diff) : diff;
	assign rem = left_q[ii] - TW'(1);
	assign dden = (tot_q[ii] == '0) ? TW'(1) : tot_q[ii];
	assign dstart = (st_q == ST_SCAN) && (i_q != CW'(NUM_CONTROLS))
		&& (left_q[ii] != '0) && (rem != '0);

	// hold the product of the ramp being stepped until the divider takes it
	logic [NW-1:0] prod_s1;
	always_ff @(posedge clk) begin
		if (dstart) prod_s1 <= NW'(mag) * NW'(rem);
	end
	assign dnum = prod_s1;

	mclre_div #(.NW(NW), .DW(TW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_go), .num(dnum), .den(dden_q),
		.busy(dbusy), .quo(dquo)
	);

	assign job_ready = (st_q == ST_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.data = out_q;

	logic [31:0] step_lvl;
	assign step_lvl = neg_q ? (tgtl_q - dquo[31:0]) : (tgtl_q + dquo[31:0]);

	// a new result beat is loaded in this cycle
	always_comb begin
		out_set = 1'b0;
		unique case (st_q)
			ST_IDLE: out_set = job_valid && !out_v_q
				&& (job.op == OP_REJECT || job.op == OP_SET);
			ST_WAIT: out_set = ({1'b0, i_q} < lim) && pend_v_q
				&& !(out_v_q && !out_ch.ready);
			ST_EMIT: out_set = !out_v_q || out_ch.ready;
			default: out_set = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (dstart) begin
			dden_q <= dden;
			neg_q <= diff[32];
			tgtl_q <= tgt_q[ii];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			i_q <= '0;
			pend_v_q <= 1'b0;
			pend_q <= '0;
			pend_lvl_q <= '0;
			out_v_q <= 1'b0;
			out_q <= '0;
			div_go <= 1'b0;
			mul_q <= 1'b0;
			for (int k = 0; k < NUM_CONTROLS; k++) begin
				cur_q[k] <= '0;
				start_q[k] <= '0;
				tgt_q[k] <= '0;
				left_q[k] <= '0;
				tot_q[k] <= TW'(1);
			end
		end else begin
			div_go <= (st_q == ST_DIV) && mul_q;
			out_v_q <= out_set || (out_v_q && !out_ch.ready);
			unique case (st_q)
				ST_IDLE: begin
					if (job_valid && !out_v_q) begin
						unique case (job.op)
							OP_REJECT: begin
								out_q <= '{out_index: job.idx, out_level: '0,
									status: 1'b1, last: 1'b1};
							end
							OP_SET: begin
								if (job.ticks != '0) left_q[job.idx[CI-1:0]] <= '0;
								cur_q[job.idx[CI-1:0]] <= job.level;
								out_q <= '{out_index: job.idx, out_level: job.level,
									status: 1'b0, last: 1'b1};
							end
							OP_RAMP: begin
								start_q[job.idx[CI-1:0]] <= cur_q[job.idx[CI-1:0]];
								tgt_q[job.idx[CI-1:0]] <= job.level;
								left_q[job.idx[CI-1:0]] <= job.ticks[TW-1:0];
								tot_q[job.idx[CI-1:0]] <= job.ticks[TW-1:0];
							end
							default: begin
								i_q <= '0;
								pend_v_q <= 1'b0;
								st_q <= ST_SCAN;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (i_q == CW'(NUM_CONTROLS)) begin
						if (pend_v_q) st_q <= ST_EMIT;
						else st_q <= ST_IDLE;
					end else if (left_q[ii] == '0) begin
						i_q <= i_q + CW'(1);
					end else begin
						left_q[ii] <= rem;
						if (rem == '0) begin
							st_q <= ST_WAIT;
							pend_lvl_q <= tgt_q[ii];
						end else begin
							mul_q <= 1'b1;
							st_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (mul_q) begin
						mul_q <= 1'b0;
					end else if (!div_go && !dbusy) begin
						pend_lvl_q <= step_lvl;
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					// index i_q holds a new level; emit the older pending one first
					if ({1'b0, i_q} < lim) begin
						if (pend_v_q && (out_v_q && !out_ch.ready)) begin
							st_q <= ST_WAIT;
						end else begin
							cur_q[ii] <= pend_lvl_q;
							if (pend_v_q) begin
								out_q <= '{out_index: IDX_W'(pend_q),
									out_level: cur_q[pend_q[CI-1:0]],
									status: 1'b0, last: 1'b0};
							end
							pend_v_q <= 1'b1;
							pend_q <= i_q;
							i_q <= i_q + CW'(1);
							st_q <= ST_SCAN;
						end
					end else begin
						i_q <= i_q + CW'(1);
						st_q <= ST_SCAN;
					end
				end
				ST_EMIT: begin
					if (!out_v_q || out_ch.ready) begin
						out_q <= '{out_index: IDX_W'(pend_q),
							out_level: cur_q[pend_q[CI-1:0]], status: 1'b0, last: 1'b1};
						pend_v_q <= 1'b0;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"
	`ASSERT_IMP(a_onehot, clk, arst_n, 1'b1, $onehot(st_q))
	`ASSERT_IMP(a_ready_idle, clk, arst_n, job_ready, st_q == ST_IDLE)
	`ASSERT_NEXT(a_hold, clk, arst_n, out_v_q && !out_ch.ready, out_v_q && $stable(out_q))
endmodule

// ----- hw/rtl/multi_channel_linear_ramp_engine_top.sv -----
// Top level of the multi-channel linear ramp engine.
//  channel | direction | payload
//  in_ch   | sink      | command, control_index, level, ramp_ticks
//  out_ch  | source    | out_index, out_level, status, last
//  cfg     | write     | cfg_we, cfg_index, cfg_data
// A set or reject shows its result beat once the back end takes its job from the
// queue and registers the beat; a continuous ramp gives no beat. A tick scans every
// control in turn, and each active ramp not on its last step waits for the serial
// divider (one quotient bit a cycle); output stalls hold the scan.
// Reset clears all levels, ramps and control state at once; no clearing pass.
// A stalled output holds the back end; the two-entry queue takes beats until full.
module multi_channel_linear_ramp_engine_top #(
	parameter int NUM_CONTROLS = 16,
	parameter int TICK_WIDTH = 16
) (
	input  logic clk,
	input  logic arst_n,
	mclre_if.sink in_ch,
	mclre_if.source out_ch,
	input  logic cfg_we,
	input  logic [mclre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mclre_pkg::CFG_W-1:0] cfg_data
);
	import mclre_pkg::*;
	logic [4:0] ciu_q;
	logic [15:0] mask_q;
	job_t job;
	logic job_valid, job_ready;

	// take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ciu_q <= 5'd16;
			mask_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CONTROLS: ciu_q <= cfg_data[4:0];
				REG_MASK: mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mclre_front #(.NUM_CONTROLS(NUM_CONTROLS), .TICK_WIDTH(TICK_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .controls_in_use(ciu_q),
		.continuous_mask(mask_q), .job(job), .job_valid(job_valid), .job_ready(job_ready)
	);

	mclre_back #(.NUM_CONTROLS(NUM_CONTROLS), .TICK_WIDTH(TICK_WIDTH)) u_back (
		.clk(clk), .arst_n(arst_n), .job(job), .job_valid(job_valid),
		.job_ready(job_ready), .controls_in_use(ciu_q), .out_ch(out_ch)
	);
endmodule

// ----- tb/mclre_ramp_checker.sv -----
// Ramp engine checker: predicts the results of every accepted beat and compares them.
module mclre_ramp_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  mclre_pkg::cmd_t in_data,
	input  logic out_valid,
	input  logic out_ready,
	input  mclre_pkg::res_t out_data,
	input  logic cfg_we,
	input  logic [mclre_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mclre_pkg::CFG_W-1:0] cfg_data,
	output int   mismatches,
	output int   pending
);
	import mclre_pkg::*;
	localparam int CTRL_N = 16;

	logic [4:0]         ctl_count;
	logic [15:0]        cont_mask;
	logic [LEVEL_W-1:0] lvl_now [CTRL_N];
	logic [LEVEL_W-1:0] lvl_from [CTRL_N];
	logic [LEVEL_W-1:0] lvl_to [CTRL_N];
	logic [TKS_W-1:0]   steps_left [CTRL_N];
	logic [TKS_W-1:0]   steps_total [CTRL_N];
	res_t               expected_res [$];
	int                 fail_cnt;

	assign mismatches = fail_cnt;

	// level partway along a ramp, quotient truncated toward zero
	function automatic logic [LEVEL_W-1:0] ramp_point(int i);
		longint tgt, diff, q;
		longint unsigned mag, tot;
		tgt = longint'($signed(lvl_to[i]));
		diff = longint'($signed(lvl_from[i])) - tgt;
		mag = (diff < 0) ? longint'(-diff) : diff;
		tot = (steps_total[i] == 0) ? 1 : steps_total[i];
		q = longint'((mag * longint'(steps_left[i])) / tot);
		return (diff < 0) ? LEVEL_W'(tgt - q) : LEVEL_W'(tgt + q);
	endfunction

	function automatic res_t mk_res(logic [IDX_W-1:0] i, logic [LEVEL_W-1:0] v, logic st);
		res_t r;
		r.out_index = i;
		r.out_level = v;
		r.status = st;
		r.last = 1'b1;
		return r;
	endfunction

	// append one expected result at the tail
	task automatic queue_res(res_t r);
		expected_res = {expected_res, r};
	endtask

	// work out the results of one command beat
	task automatic predict_beat(cmd_t c);
		int lim, i;
		logic [IDX_W-1:0] idx;
		logic [TKS_W-1:0] tks;
		logic [LEVEL_W-1:0] v;
		res_t r;
		bit any;
		lim = (ctl_count < CTRL_N) ? ctl_count : CTRL_N;
		idx = c.control_index;
		any = 0;
		if (c.command == CMD_SET || c.command == CMD_RAMP) begin
			if (idx >= lim) begin
				queue_res(mk_res(idx, '0, 1'b1));
			end else if (c.command == CMD_RAMP && cont_mask[idx]) begin
				tks = (c.ramp_ticks == 0) ? TKS_W'(1) : c.ramp_ticks;
				lvl_from[idx] = lvl_now[idx];
				lvl_to[idx] = c.level;
				steps_left[idx] = tks;
				steps_total[idx] = tks;
			end else begin
				if (c.command == CMD_SET)
					steps_left[idx] = '0;
				lvl_now[idx] = c.level;
				queue_res(mk_res(idx, c.level, 1'b0));
			end
		end else if (c.command == CMD_TICK) begin
			for (i = 0; i < CTRL_N; i++) begin
				if (steps_left[i] != 0) begin
					steps_left[i] = steps_left[i] - TKS_W'(1);
					v = (steps_left[i] == 0) ? lvl_to[i] : ramp_point(i);
					if (i < lim) begin
						lvl_now[i] = v;
						r = mk_res(IDX_W'(i), v, 1'b0);
						r.last = 1'b0;
						queue_res(r);
						any = 1;
					end
				end
			end
			// mark the final result of the tick
			if (any) begin
				r = expected_res.pop_back();
				r.last = 1'b1;
				queue_res(r);
			end
		end
	endtask

	// compare one result beat with the oldest expectation
	task automatic check_beat(res_t got);
		res_t exp_r;
		if (expected_res.size() == 0) begin
			$display("%0t: unexpected result idx %0d level %0d status %0d last %0d", $time,
				got.out_index, got.out_level, got.status, got.last);
			fail_cnt++;
		end else begin
			exp_r = expected_res.pop_front();
			if (got.out_index !== exp_r.out_index) begin
				$display("%0t: out_index expected %0d actual %0d", $time,
					exp_r.out_index, got.out_index);
				fail_cnt++;
			end
			if (got.out_level !== exp_r.out_level) begin
				$display("%0t: out_level expected %0d actual %0d", $time,
					exp_r.out_level, got.out_level);
				fail_cnt++;
			end
			if (got.status !== exp_r.status) begin
				$display("%0t: status expected %0d actual %0d", $time, exp_r.status, got.status);
				fail_cnt++;
			end
			if (got.last !== exp_r.last) begin
				$display("%0t: last expected %0d actual %0d", $time, exp_r.last, got.last);
				fail_cnt++;
			end
		end
	endtask

	// hold reset state, then track configuration, commands and results
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_count <= 5'd16;
			cont_mask <= '0;
			pending = 0;
			for (int i = 0; i < CTRL_N; i++) begin
				lvl_now[i] = '0;
				lvl_from[i] = '0;
				lvl_to[i] = '0;
				steps_left[i] = '0;
				steps_total[i] = TKS_W'(1);
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_CONTROLS)
					ctl_count <= cfg_data[4:0];
				else if (cfg_index == REG_MASK)
					cont_mask <= cfg_data;
			end
			if (in_valid && in_ready)
				predict_beat(in_data);
			if (out_valid && out_ready)
				check_beat(out_data);
			pending = expected_res.size();
		end
	end

	initial fail_cnt = 0;
endmodule

// ----- tb/tb_multi_channel_linear_ramp_engine_top.sv -----
// Testbench top: clock, reset, command and configuration stimulus, result sink, verdict.
module tb_multi_channel_linear_ramp_engine_top;
	import mclre_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 1200;
	localparam int LONG_HOLD = 600;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int mismatches;
	int pending;
	bit long_hold_req;

	mclre_if #(.T(cmd_t)) in_ch ();
	mclre_if #(.T(res_t)) out_ch ();

	multi_channel_linear_ramp_engine_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	mclre_ramp_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.in_data(in_ch.data),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.out_data(out_ch.data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// end the run if it hangs
	initial begin
		#30000000;
		$display("tb: failure");
		$finish;
	end

	function automatic cmd_t mk_cmd(logic [CMD_W-1:0] c, logic [IDX_W-1:0] i,
		logic [LEVEL_W-1:0] l, logic [TKS_W-1:0] t);
		cmd_t r;
		r.command = c;
		r.control_index = i;
		r.level = l;
		r.ramp_ticks = t;
		return r;
	endfunction

	// random command, mostly ramps and ticks with short lengths
	function automatic cmd_t rand_cmd();
		int w;
		logic [CMD_W-1:0] c;
		logic [LEVEL_W-1:0] l;
		logic [TKS_W-1:0] t;
		w = $urandom_range(0, 99);
		c = (w < 20) ? CMD_SET : (w < 58) ? CMD_RAMP : (w < 96) ? CMD_TICK : CMD_UNUSED;
		l = ($urandom_range(0, 2) == 0) ? $urandom : LEVEL_W'($signed($urandom_range(0, 2000)) - 1000);
		w = $urandom_range(0, 19);
		t = (w == 0) ? TKS_W'($urandom) : (w == 1) ? '1 : TKS_W'($urandom_range(0, 8));
		return mk_cmd(c, IDX_W'($urandom_range(0, 15)), l, t);
	endfunction

	// offer one command beat after a random gap and wait until it is taken
	task automatic send_beat(cmd_t c);
		int gap;
		gap = $urandom_range(0, 10);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.data <= c;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// drop valid and wait until every result has come and the back end is quiet
	task automatic drain();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] r, logic [CFG_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic rand_phase(int n);
		for (int k = 0; k < n; k++)
			send_beat(rand_cmd());
	endtask

	// result sink: random stalls per beat, one long hold on request
	initial begin
		int gap;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				gap = LONG_HOLD;
				long_hold_req = 0;
			end else begin
				gap = $urandom_range(0, 10);
			end
			if (gap > 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	// stimulus and verdict
	initial begin
		long_hold_req = 0;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.data <= '0;
		cfg_we <= 1'b0;
		cfg_index <= REG_CONTROLS;
		cfg_data <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: nothing continuous, so ramps write at once
		send_beat(mk_cmd(CMD_SET, 4'd0, 32'h7FFF_FFFF, 16'd0));
		send_beat(mk_cmd(CMD_SET, 4'd15, 32'h8000_0000, 16'hFFFF));
		send_beat(mk_cmd(CMD_RAMP, 4'd3, 32'h0001_8000, 16'd5));
		send_beat(mk_cmd(CMD_TICK, 4'd0, 32'd0, 16'd0));
		send_beat(mk_cmd(CMD_UNUSED, 4'd2, 32'hFFFF_FFFF, 16'hFFFF));
		drain();

		// all continuous: ramps of length zero (taken as one), short, long, and extreme levels
		write_reg(REG_MASK, 16'hFFFF);
		send_beat(mk_cmd(CMD_RAMP, 4'd0, 32'h8000_0000, 16'd3));
		send_beat(mk_cmd(CMD_RAMP, 4'd15, 32'h7FFF_FFFF, 16'd0));
		send_beat(mk_cmd(CMD_RAMP, 4'd5, 32'h0000_0001, 16'hFFFF));
		send_beat(mk_cmd(CMD_RAMP, 4'd7, 32'hFFFF_0000, 16'd7));
		send_beat(mk_cmd(CMD_TICK, 4'd0, 32'd0, 16'd0));
		send_beat(mk_cmd(CMD_RAMP, 4'd7, 32'h0010_0000, 16'd2));
		send_beat(mk_cmd(CMD_TICK, 4'd9, 32'd0, 16'd0));
		send_beat(mk_cmd(CMD_SET, 4'd5, 32'h1234_5678, 16'd0));
		send_beat(mk_cmd(CMD_TICK, 4'd0, 32'd0, 16'd0));
		send_beat(mk_cmd(CMD_TICK, 4'd0, 32'd0, 16'd0));
		send_beat(mk_cmd(CMD_RAMP, 4'd12, 32'h0000_0100, 16'd4));
		drain();

		// shrink the control count while ramps run, then reject indices
		write_reg(REG_CONTROLS, 16'd4);
		send_beat(mk_cmd(CMD_TICK, 4'd0, 32'd0, 16'd0));
		send_beat(mk_cmd(CMD_SET, 4'd4, 32'h0000_0042, 16'd0));
		send_beat(mk_cmd(CMD_RAMP, 4'd3, 32'h0002_0000, 16'd2));
		drain();

		// drop the mask with a ramp running, then write that control directly
		write_reg(REG_MASK, 16'h0000);
		send_beat(mk_cmd(CMD_RAMP, 4'd3, 32'h0000_0077, 16'd9));
		send_beat(mk_cmd(CMD_TICK, 4'd0, 32'd0, 16'd0));
		drain();

		// no controls at all
		write_reg(REG_CONTROLS, 16'd0);
		send_beat(mk_cmd(CMD_SET, 4'd0, 32'h0000_0001, 16'd0));
		send_beat(mk_cmd(CMD_RAMP, 4'd15, 32'h0000_0001, 16'd1));
		send_beat(mk_cmd(CMD_TICK, 4'd0, 32'd0, 16'd0));
		drain();

		// random phases over several settings; one long sink hold
		write_reg(REG_CONTROLS, 16'd16);
		write_reg(REG_MASK, 16'hFFFF);
		long_hold_req = 1;
		rand_phase(120);
		drain();
		write_reg(REG_CONTROLS, CFG_W'($urandom_range(0, 16)));
		write_reg(REG_MASK, CFG_W'($urandom));
		rand_phase(100);
		drain();
		write_reg(REG_CONTROLS, 16'd16);
		write_reg(REG_MASK, CFG_W'($urandom));
		rand_phase(110);
		drain();
		write_reg(REG_CONTROLS, 16'd8);
		write_reg(REG_MASK, 16'hFFFF);
		rand_phase(100);
		drain();

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/mclre_pkg.sv
hw/rtl/mclre_if.sv
hw/rtl/mclre_front.sv
hw/rtl/mclre_div.sv
hw/rtl/mclre_back.sv
hw/rtl/multi_channel_linear_ramp_engine_top.sv
tb/mclre_ramp_checker.sv
tb/tb_multi_channel_linear_ramp_engine_top.sv
